// File: hw/rtl/bvsg_pkg.sv
// Shared types, constants and the sine table of the body velocity setpoint generator.
package bvsg_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1073741824;

    localparam logic [1:0] REQ_COMMAND  = 2'd0;
    localparam logic [1:0] REQ_POSITION = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_ALT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HORIZ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERT    = 3'd5;

    localparam logic [16:0] RST_CRUISE_ALT  = 17'd2500;
    localparam logic [14:0] RST_MAX_HORIZ   = 15'd1500;
    localparam logic [14:0] RST_MAX_TURN    = 15'd800;
    localparam logic [23:0] RST_CMD_TIMEOUT = 24'd500000;
    localparam logic [15:0] RST_ALT_GAIN    = 16'd256;
    localparam logic [14:0] RST_MAX_VERT    = 15'd1000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [63:0]        time_us;
        logic signed [15:0] cmd_forward_vel;
        logic signed [15:0] cmd_left_vel;
        logic signed [15:0] cmd_turn_rate;
        logic [15:0]        heading_angle;
        logic signed [23:0] down_position_mm;
        logic               horiz_pos_valid;
        logic               vert_pos_valid;
    } t_in_item;

    typedef struct packed {
        logic               setpoint_valid;
        logic signed [15:0] north_vel;
        logic signed [15:0] east_vel;
        logic signed [15:0] down_vel;
        logic signed [15:0] yaw_rate_cw;
        logic               command_stale;
        logic [63:0]        stamp_us;
    } t_out_item;

    typedef struct packed {
        logic [16:0] cruise_altitude_mm;
        logic [14:0] max_horizontal_speed;
        logic [14:0] max_turn_rate;
        logic [23:0] command_timeout_us;
        logic [15:0] altitude_gain;
        logic [14:0] max_vertical_speed;
    } t_cfg;

    typedef struct packed {
        logic               pos_ok;
        logic               stale;
        logic signed [15:0] fwd;
        logic signed [15:0] left;
        logic signed [15:0] turn;
        logic signed [15:0] sin_a;
        logic signed [15:0] cos_a;
        logic signed [24:0] alt_err;
        logic [63:0]        stamp;
    } t_stage1;

    typedef logic [SINE_TABLE_DEPTH-1:0][15:0] t_sine_tab;

    // shift-subtract quotient, evaluated only while building the table
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q1.15 sine over one full turn, built from a Q30 Taylor series
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        longint      q;
        longint      r;
        longint      x;
        longint      sum;
        longint      v;
        logic [63:0] term;
        logic [63:0] d;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            q = (4 * k) / SINE_TABLE_DEPTH;
            r = 4 * k - q * SINE_TABLE_DEPTH;
            x = HALF_PI_Q30 * r / SINE_TABLE_DEPTH;
            term = q[0] ? 64'(Q30_ONE) : 64'(x);
            sum = longint'(term);
            for (int n = 1; n <= 9; n++) begin
                d = q[0] ? 64'((2 * n - 1) * (2 * n)) : 64'((2 * n) * (2 * n + 1));
                term = (term * 64'(x)) >> 30;
                term = (term * 64'(x)) >> 30;
                term = udiv64(term, d);
                if (n[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum * 32767 + Q30_ONE / 2) >>> 30;
            if (v > 32767) begin
                v = 32767;
            end
            tab[k] = (q >= 2) ? 16'(-v) : 16'(v);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

    function automatic logic [SINE_AW-1:0] sine_index(logic [15:0] angle);
        logic [31:0] p;
        p = 32'(angle) * 32'(SINE_TABLE_DEPTH);
        return p[16 +: SINE_AW];
    endfunction

endpackage

// File: hw/rtl/bvsg_req_if.sv
// Event input channel: valid, ready and one event item.
interface bvsg_req_if;
    logic               valid;
    logic               ready;
    bvsg_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/bvsg_rsp_if.sv
// Result output channel: valid, ready and one setpoint item.
interface bvsg_rsp_if;
    logic                valid;
    logic                ready;
    bvsg_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/bvsg_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
interface bvsg_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bvsg_pkg::CFG_IDX_W-1:0]     index;
    logic [bvsg_pkg::CFG_DATA_W-1:0]    wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: hw/rtl/bvsg_cfg_regs.sv
// Configuration register file with reset defaults.
module bvsg_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bvsg_cfg_if.sink        i_cfg,
    output bvsg_pkg::t_cfg  o_cfg
);

    bvsg_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise_altitude_mm   <= bvsg_pkg::RST_CRUISE_ALT;
            r_cfg.max_horizontal_speed <= bvsg_pkg::RST_MAX_HORIZ;
            r_cfg.max_turn_rate        <= bvsg_pkg::RST_MAX_TURN;
            r_cfg.command_timeout_us   <= bvsg_pkg::RST_CMD_TIMEOUT;
            r_cfg.altitude_gain        <= bvsg_pkg::RST_ALT_GAIN;
            r_cfg.max_vertical_speed   <= bvsg_pkg::RST_MAX_VERT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bvsg_pkg::CFG_CRUISE_ALT: begin
                    r_cfg.cruise_altitude_mm <= i_cfg.wdata[16:0];
                end
                bvsg_pkg::CFG_MAX_HORIZ: begin
                    r_cfg.max_horizontal_speed <= i_cfg.wdata[14:0];
                end
                bvsg_pkg::CFG_MAX_TURN: begin
                    r_cfg.max_turn_rate <= i_cfg.wdata[14:0];
                end
                bvsg_pkg::CFG_CMD_TIMEOUT: begin
                    r_cfg.command_timeout_us <= i_cfg.wdata[23:0];
                end
                bvsg_pkg::CFG_ALT_GAIN: begin
                    r_cfg.altitude_gain <= i_cfg.wdata[15:0];
                end
                bvsg_pkg::CFG_MAX_VERT: begin
                    r_cfg.max_vertical_speed <= i_cfg.wdata[14:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/bvsg_front.sv
// Event state, command freshness, clamping, sine lookup and the operand register.
module bvsg_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bvsg_req_if.sink           i_req,
    input  bvsg_pkg::t_cfg     i_cfg,
    output bvsg_pkg::t_stage1  o_s1,
    output logic               o_s1_valid,
    input  logic               i_s1_ready
);

    logic signed [15:0] r_cmd_fwd;
    logic signed [15:0] r_cmd_left;
    logic signed [15:0] r_cmd_turn;
    logic [63:0]        r_cmd_time;
    logic               r_cmd_seen;
    logic [15:0]        r_heading;
    logic signed [23:0] r_down_pos;
    logic               r_pos_ok;

    logic               r_v1;
    bvsg_pkg::t_stage1  r_s1;
    bvsg_pkg::t_stage1  n_s1;

    logic        rdy1;
    logic        acc;
    logic        is_tick;
    logic        tick_acc;
    logic [63:0] age;
    logic        fresh;
    logic [15:0] ang;
    logic [15:0] ang_cos;

    function automatic logic signed [15:0] clamp16(logic signed [15:0] v, logic [14:0] lim);
        logic signed [16:0] vv;
        logic signed [16:0] hi;
        vv = {v[15], v};
        hi = {2'b00, lim};
        if (vv > hi) begin
            return {1'b0, lim};
        end else if (vv < -hi) begin
            return 16'(-hi);
        end
        return v;
    endfunction

    assign rdy1        = !r_v1 || i_s1_ready;
    assign i_req.ready = rdy1;
    assign acc         = i_req.valid && rdy1;
    assign is_tick     = i_req.data.req_type == bvsg_pkg::REQ_TICK;
    assign o_s1        = r_s1;
    assign o_s1_valid  = r_v1;
    assign tick_acc    = acc && is_tick;

    assign age     = i_req.data.time_us - r_cmd_time;
    assign fresh   = r_cmd_seen && ((i_req.data.time_us < r_cmd_time) ||
                                    (age < {40'd0, i_cfg.command_timeout_us}));
    assign ang     = 16'd16384 - r_heading;
    assign ang_cos = ang + 16'd16384;

    always_comb begin
        n_s1.pos_ok  = r_pos_ok;
        n_s1.stale   = r_cmd_seen && !fresh;
        n_s1.fwd     = fresh ? clamp16(r_cmd_fwd, i_cfg.max_horizontal_speed) : 16'sd0;
        n_s1.left    = fresh ? clamp16(r_cmd_left, i_cfg.max_horizontal_speed) : 16'sd0;
        n_s1.turn    = fresh ? clamp16(r_cmd_turn, i_cfg.max_turn_rate) : 16'sd0;
        n_s1.sin_a   = bvsg_pkg::SINE_TAB[bvsg_pkg::sine_index(ang)];
        n_s1.cos_a   = bvsg_pkg::SINE_TAB[bvsg_pkg::sine_index(ang_cos)];
        n_s1.alt_err = $signed({8'd0, i_cfg.cruise_altitude_mm}) +
                       $signed({r_down_pos[23], r_down_pos});
        n_s1.stamp   = i_req.data.time_us;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_seen <= 1'b0;
            r_pos_ok   <= 1'b0;
            r_v1       <= 1'b0;
        end else begin
            if (acc && i_req.data.req_type == bvsg_pkg::REQ_COMMAND) begin
                r_cmd_seen <= 1'b1;
            end
            if (acc && i_req.data.req_type == bvsg_pkg::REQ_POSITION) begin
                r_pos_ok <= i_req.data.horiz_pos_valid && i_req.data.vert_pos_valid;
            end
            if (rdy1) begin
                r_v1 <= tick_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_req.data.req_type == bvsg_pkg::REQ_COMMAND) begin
            r_cmd_fwd  <= i_req.data.cmd_forward_vel;
            r_cmd_left <= i_req.data.cmd_left_vel;
            r_cmd_turn <= i_req.data.cmd_turn_rate;
            r_cmd_time <= i_req.data.time_us;
        end
        if (acc && i_req.data.req_type == bvsg_pkg::REQ_POSITION) begin
            r_heading  <= i_req.data.heading_angle;
            r_down_pos <= i_req.data.down_position_mm;
        end
        if (tick_acc) begin
            r_s1 <= n_s1;
        end
    end

    a_tick_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> r_v1)
        else $error("accepted tick did not reach the operand register");

    a_stale_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_s1.stale |-> r_s1.fwd == 16'sd0 && r_s1.left == 16'sd0 &&
                               r_s1.turn == 16'sd0)
        else $error("stale command carries nonzero velocity");

endmodule

// File: hw/rtl/bvsg_back.sv
// Rotation and altitude products, rounding, saturation and the result register.
module bvsg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bvsg_pkg::t_cfg     i_cfg,
    input  bvsg_pkg::t_stage1  i_s1,
    input  logic               i_s1_valid,
    output logic               o_s1_ready,
    bvsg_rsp_if.source         o_rsp
);

    logic               r_v2;
    logic signed [31:0] r_fs;
    logic signed [31:0] r_lc;
    logic signed [31:0] r_fc;
    logic signed [31:0] r_ls;
    logic signed [40:0] r_pe;
    logic               r_pos_ok;
    logic               r_stale;
    logic signed [15:0] r_turn;
    logic [63:0]        r_stamp;

    logic                r_v3;
    bvsg_pkg::t_out_item r_out;
    bvsg_pkg::t_out_item n_out;

    logic               rdy2;
    logic               rdy3;
    logic signed [16:0] gain_s;
    logic signed [41:0] pe_full;
    logic signed [33:0] north_sum;
    logic signed [33:0] east_sum;
    logic signed [33:0] north_sh;
    logic signed [33:0] east_sh;
    logic signed [41:0] p_sum;
    logic signed [41:0] p_sh;
    logic signed [41:0] v_lim;
    logic signed [41:0] p_clamp;
    logic signed [16:0] yaw_neg;

    function automatic logic signed [15:0] sat16(logic signed [33:0] v);
        if (v > 34'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -34'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    assign rdy3       = !r_v3 || o_rsp.ready;
    assign rdy2       = !r_v2 || rdy3;
    assign o_s1_ready = rdy2;
    assign o_rsp.valid = r_v3;
    assign o_rsp.data  = r_out;

    assign gain_s  = {1'b0, i_cfg.altitude_gain};
    assign pe_full = gain_s * i_s1.alt_err;

    assign north_sum = 34'(r_fs) + 34'(r_lc) + 34'sd16384;
    assign east_sum  = 34'(r_fc) - 34'(r_ls) + 34'sd16384;
    assign north_sh  = north_sum >>> 15;
    assign east_sh   = east_sum >>> 15;
    assign p_sum     = 42'(r_pe) + 42'sd128;
    assign p_sh      = p_sum >>> 8;
    assign v_lim     = $signed({27'd0, i_cfg.max_vertical_speed});
    assign yaw_neg   = -{r_turn[15], r_turn};

    always_comb begin
        if (p_sh > v_lim) begin
            p_clamp = v_lim;
        end else if (p_sh < -v_lim) begin
            p_clamp = -v_lim;
        end else begin
            p_clamp = p_sh;
        end
        n_out.setpoint_valid = r_pos_ok;
        n_out.stamp_us       = r_stamp;
        if (r_pos_ok) begin
            n_out.north_vel     = sat16(north_sh);
            n_out.east_vel      = sat16(east_sh);
            n_out.down_vel      = 16'(-p_clamp);
            n_out.yaw_rate_cw   = yaw_neg[15:0];
            n_out.command_stale = r_stale;
        end else begin
            n_out.north_vel     = 16'sd0;
            n_out.east_vel      = 16'sd0;
            n_out.down_vel      = 16'sd0;
            n_out.yaw_rate_cw   = 16'sd0;
            n_out.command_stale = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_s1_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_s1_valid) begin
            r_fs     <= i_s1.fwd * i_s1.sin_a;
            r_lc     <= i_s1.left * i_s1.cos_a;
            r_fc     <= i_s1.fwd * i_s1.cos_a;
            r_ls     <= i_s1.left * i_s1.sin_a;
            r_pe     <= pe_full[40:0];
            r_pos_ok <= i_s1.pos_ok;
            r_stale  <= i_s1.stale;
            r_turn   <= i_s1.turn;
            r_stamp  <= i_s1.stamp;
        end
        if (rdy3 && r_v2) begin
            r_out <= n_out;
        end
    end

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && rdy3 |=> r_v3)
        else $error("product stage lost a transaction");

    a_no_setpoint_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_out.setpoint_valid |-> r_out.north_vel == 16'sd0 &&
            r_out.east_vel == 16'sd0 && r_out.down_vel == 16'sd0 &&
            r_out.yaw_rate_cw == 16'sd0 && !r_out.command_stale)
        else $error("result without setpoint carries nonzero fields");

    a_down_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_out.setpoint_valid |->
            $signed({r_out.down_vel[15], r_out.down_vel}) <=
                $signed({2'b00, i_cfg.max_vertical_speed}) &&
            $signed({r_out.down_vel[15], r_out.down_vel}) >=
                -$signed({2'b00, i_cfg.max_vertical_speed}))
        else $error("down velocity outside vertical limit");

endmodule

// File: hw/rtl/body_velocity_setpoint_generator.sv
// Top level of the body velocity setpoint generator.
// Takes one event per clock while o_rsp is ready: command and position events update internal
// state in the cycle they are accepted and give no result; a tick event is captured in the
// operand register at acceptance, then passes the product register and the result register,
// which raises o_rsp valid. Up to three ticks are in flight, so while o_rsp is ready the
// sustained rate is one event per cycle. While a finished result waits on o_rsp, new events
// are still taken until the operand and product registers fill; with all three holding ticks
// every event waits. The configuration port is always ready and should be written only while
// no tick is in flight.
module body_velocity_setpoint_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bvsg_req_if.sink    i_req,
    bvsg_rsp_if.source  o_rsp,
    bvsg_cfg_if.sink    i_cfg
);

    bvsg_pkg::t_cfg    cfg;
    bvsg_pkg::t_stage1 s1;
    logic              s1_valid;
    logic              s1_ready;

    bvsg_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    bvsg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg      (cfg),
        .o_s1       (s1),
        .o_s1_valid (s1_valid),
        .i_s1_ready (s1_ready)
    );

    bvsg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s1       (s1),
        .i_s1_valid (s1_valid),
        .o_s1_ready (s1_ready),
        .o_rsp      (o_rsp)
    );

endmodule
